[rtl/ptl_pkg.sv]
package ptl_pkg;

    // default coordinate width, two's complement
    localparam int COORD_WIDTH_DEF = 32;

    // cell rows
    localparam int DIV_QW_DEF  = COORD_WIDTH_DEF + 1;
    localparam int DIV_UW_DEF  = 2 * COORD_WIDTH_DEF + 2;
    localparam int SQRT_RW_DEF = COORD_WIDTH_DEF + 2;

endpackage

[rtl/ptl_div_cell.sv]
module ptl_div_cell #(
    parameter int QW = ptl_pkg::DIV_QW_DEF,
    parameter int UW = ptl_pkg::DIV_UW_DEF
) (
    input  logic          clk,
    input  logic [UW-1:0] rem_in,
    input  logic [QW-1:0] num_in,
    input  logic [QW-1:0] quo_in,
    input  logic [UW-1:0] uu_in,
    output logic [UW-1:0] rem_out,
    output logic [QW-1:0] num_out,
    output logic [QW-1:0] quo_out,
    output logic [UW-1:0] uu_out
);

    logic [UW:0]   trial;
    logic [UW:0]   diff;
    logic          ge;
    logic [UW-1:0] rem_next;
    logic [UW-1:0] rem_reg;
    logic [QW-1:0] num_next;
    logic [QW-1:0] num_reg;
    logic [QW-1:0] quo_next;
    logic [QW-1:0] quo_reg;
    logic [UW-1:0] uu_reg;

    // one restoring step: bring down the next numerator bit
    assign trial = {rem_in, num_in[QW-1]};
    assign diff  = trial - {1'b0, uu_in};
    assign ge    = (trial >= {1'b0, uu_in});

    assign rem_next = ge ? diff[UW-1:0] : trial[UW-1:0];
    assign num_next = {num_in[QW-2:0], 1'b0};
    assign quo_next = {quo_in[QW-2:0], ge};

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        num_reg <= num_next;
        quo_reg <= quo_next;
        uu_reg  <= uu_in;
    end

    assign rem_out = rem_reg;
    assign num_out = num_reg;
    assign quo_out = quo_reg;
    assign uu_out  = uu_reg;

endmodule

[rtl/ptl_sqrt_cell.sv]
module ptl_sqrt_cell #(
    parameter int RW = ptl_pkg::SQRT_RW_DEF
) (
    input  logic            clk,
    input  logic [RW+1:0]   rem_in,
    input  logic [2*RW-1:0] src_in,
    input  logic [RW-1:0]   root_in,
    output logic [RW+1:0]   rem_out,
    output logic [2*RW-1:0] src_out,
    output logic [RW-1:0]   root_out
);

    logic [RW+3:0]   t;
    logic [RW+3:0]   trial;
    logic [RW+3:0]   diff;
    logic            ge;
    logic [RW+1:0]   rem_next;
    logic [RW+1:0]   rem_reg;
    logic [2*RW-1:0] src_next;
    logic [2*RW-1:0] src_reg;
    logic [RW-1:0]   root_next;
    logic [RW-1:0]   root_reg;

    // digit-by-digit root: two radicand bits per cell
    assign t     = {rem_in, src_in[2*RW-1 -: 2]};
    assign trial = {2'b00, root_in, 2'b01};
    assign diff  = t - trial;
    assign ge    = (t >= trial);

    assign rem_next  = ge ? diff[RW+1:0] : t[RW+1:0];
    assign src_next  = {src_in[2*RW-3:0], 2'b00};
    assign root_next = {root_in[RW-2:0], ge};

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        src_reg  <= src_next;
        root_reg <= root_next;
    end

    assign rem_out  = rem_reg;
    assign src_out  = src_reg;
    assign root_out = root_reg;

endmodule

[rtl/point_to_line_distance_core.sv]
// channel   direction  handshake     fields
// ------    ---------  ---------     ------
// query     in         start / busy  line_start_x/y, line_end_x/y, point_x/y
// result    out        done strobe   perp_x, perp_y, distance, overflow, degenerate
//
// one item accepted every cycle; busy is never raised
// pipeline: five multiply/setup stages, a row of COORD_WIDTH+1 divider cells,
// three stages, COORD_WIDTH+2 root cells, and the output register
// reset clears only the valid line; results cannot be stalled by the receiver
module point_to_line_distance_core #(
    parameter int COORD_WIDTH = ptl_pkg::COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] line_start_x,
    input  logic signed [COORD_WIDTH-1:0] line_start_y,
    input  logic signed [COORD_WIDTH-1:0] line_end_x,
    input  logic signed [COORD_WIDTH-1:0] line_end_y,
    input  logic signed [COORD_WIDTH-1:0] point_x,
    input  logic signed [COORD_WIDTH-1:0] point_y,
    output logic                          done,
    output logic signed [COORD_WIDTH-1:0] perp_x,
    output logic signed [COORD_WIDTH-1:0] perp_y,
    output logic        [COORD_WIDTH-1:0] distance,
    output logic                          overflow,
    output logic                          degenerate
);

    import ptl_pkg::*;

    localparam int W    = COORD_WIDTH;
    localparam int DW   = W + 1;
    localparam int PW   = 2 * DW;
    localparam int UW   = 2 * DW;
    localparam int NUMW = 3 * W + 4;
    localparam int RW   = W + 2;
    localparam int LAT  = 2 * W + 12;
    localparam int DSW  = 2 * DW + 3;
    localparam int SSW  = 2 * W + 2;

    logic accept;
    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] vld_next;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign vld_next = {vld_reg[LAT-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // stage 1: offsets
    logic signed [DW-1:0] s1_dx_reg, s1_dy_reg, s1_ux_reg, s1_uy_reg;
    logic signed [DW-1:0] s1_dx_next, s1_dy_next, s1_ux_next, s1_uy_next;

    assign s1_dx_next = $signed({point_x[W-1], point_x})
                      - $signed({line_start_x[W-1], line_start_x});
    assign s1_dy_next = $signed({point_y[W-1], point_y})
                      - $signed({line_start_y[W-1], line_start_y});
    assign s1_ux_next = $signed({line_end_x[W-1], line_end_x})
                      - $signed({line_start_x[W-1], line_start_x});
    assign s1_uy_next = $signed({line_end_y[W-1], line_end_y})
                      - $signed({line_start_y[W-1], line_start_y});

    // stage 2: products
    logic signed [PW-1:0] s2_dxux_reg, s2_dyuy_reg, s2_uxux_reg, s2_uyuy_reg;
    logic signed [DW-1:0] s2_dx_reg, s2_dy_reg, s2_ux_reg, s2_uy_reg;
    logic                 s2_deg_reg;

    // stage 3: dot product magnitude, squared length
    logic [PW:0]          s3_dot_u;
    logic [PW:0]          s3_dot_mag;
    logic [UW-1:0]        s3_uu_next;
    logic [DW-1:0]        s3_uxm_next, s3_uym_next;
    logic [W-1:0]         s3_lo_reg;
    logic [PW-W:0]        s3_hi_reg;
    logic [UW-1:0]        s3_uu_reg;
    logic [DW-1:0]        s3_uxm_reg, s3_uym_reg;
    logic                 s3_negx_reg, s3_negy_reg, s3_deg_reg;
    logic signed [DW-1:0] s3_dx_reg, s3_dy_reg;

    assign s3_dot_u = {s2_dxux_reg[PW-1], s2_dxux_reg}
                    + {s2_dyuy_reg[PW-1], s2_dyuy_reg};
    assign s3_dot_mag = s3_dot_u[PW] ? (~s3_dot_u + 1'b1) : s3_dot_u;
    assign s3_uu_next = {1'b0, s2_uxux_reg[PW-2:0]} + {1'b0, s2_uyuy_reg[PW-2:0]};
    assign s3_uxm_next = s2_ux_reg[DW-1] ? DW'(-s2_ux_reg) : DW'(s2_ux_reg);
    assign s3_uym_next = s2_uy_reg[DW-1] ? DW'(-s2_uy_reg) : DW'(s2_uy_reg);

    // stage 4: partial products of the numerators
    logic [W+DW-1:0]    s4_lox_reg, s4_loy_reg;
    logic [PW-W+DW:0]   s4_hix_reg, s4_hiy_reg;
    logic [UW-1:0]      s4_uu_reg;
    logic [DSW-1:0]     s4_side_reg;

    // stage 5: numerators
    logic [NUMW-1:0]    s5_numx_next, s5_numy_next;
    logic [NUMW-1:0]    s5_numx_reg, s5_numy_reg;
    logic [UW-1:0]      s5_uu_reg;
    logic [DSW-1:0]     s5_side_reg;

    assign s5_numx_next = {s4_hix_reg, {W{1'b0}}}
                        + {{(NUMW - W - DW){1'b0}}, s4_lox_reg};
    assign s5_numy_next = {s4_hiy_reg, {W{1'b0}}}
                        + {{(NUMW - W - DW){1'b0}}, s4_loy_reg};

    always_ff @(posedge clk)
    begin
        s1_dx_reg   <= s1_dx_next;
        s1_dy_reg   <= s1_dy_next;
        s1_ux_reg   <= s1_ux_next;
        s1_uy_reg   <= s1_uy_next;

        s2_dxux_reg <= s1_dx_reg * s1_ux_reg;
        s2_dyuy_reg <= s1_dy_reg * s1_uy_reg;
        s2_uxux_reg <= s1_ux_reg * s1_ux_reg;
        s2_uyuy_reg <= s1_uy_reg * s1_uy_reg;
        s2_dx_reg   <= s1_dx_reg;
        s2_dy_reg   <= s1_dy_reg;
        s2_ux_reg   <= s1_ux_reg;
        s2_uy_reg   <= s1_uy_reg;
        s2_deg_reg  <= (s1_ux_reg == '0) && (s1_uy_reg == '0);

        s3_lo_reg   <= s3_dot_mag[W-1:0];
        s3_hi_reg   <= s3_dot_mag[PW:W];
        s3_uu_reg   <= s3_uu_next;
        s3_uxm_reg  <= s3_uxm_next;
        s3_uym_reg  <= s3_uym_next;
        s3_negx_reg <= s3_dot_u[PW] ^ s2_ux_reg[DW-1];
        s3_negy_reg <= s3_dot_u[PW] ^ s2_uy_reg[DW-1];
        s3_deg_reg  <= s2_deg_reg;
        s3_dx_reg   <= s2_dx_reg;
        s3_dy_reg   <= s2_dy_reg;

        s4_lox_reg  <= s3_lo_reg * s3_uxm_reg;
        s4_loy_reg  <= s3_lo_reg * s3_uym_reg;
        s4_hix_reg  <= s3_hi_reg * s3_uxm_reg;
        s4_hiy_reg  <= s3_hi_reg * s3_uym_reg;
        s4_uu_reg   <= s3_uu_reg;
        s4_side_reg <= {s3_dx_reg, s3_dy_reg, s3_negx_reg, s3_negy_reg, s3_deg_reg};

        s5_numx_reg <= s5_numx_next;
        s5_numy_reg <= s5_numy_next;
        s5_uu_reg   <= s4_uu_reg;
        s5_side_reg <= s4_side_reg;
    end

    // divider rows, one quotient bit per cell
    logic [UW-1:0] divx_rem [DW+1];
    logic [DW-1:0] divx_num [DW+1];
    logic [DW-1:0] divx_quo [DW+1];
    logic [UW-1:0] divx_uu  [DW+1];
    logic [UW-1:0] divy_rem [DW+1];
    logic [DW-1:0] divy_num [DW+1];
    logic [DW-1:0] divy_quo [DW+1];
    logic [UW-1:0] divy_uu  [DW+1];
    logic [DSW-1:0] dside_reg [DW];

    // quotient stays below 2^(W+1), so the top part starts below the divisor
    assign divx_rem[0] = s5_numx_reg[DW+UW-1:DW];
    assign divx_num[0] = s5_numx_reg[DW-1:0];
    assign divx_quo[0] = '0;
    assign divx_uu[0]  = s5_uu_reg;
    assign divy_rem[0] = s5_numy_reg[DW+UW-1:DW];
    assign divy_num[0] = s5_numy_reg[DW-1:0];
    assign divy_quo[0] = '0;
    assign divy_uu[0]  = s5_uu_reg;

    for (genvar k = 0; k < DW; k++)
    begin : g_div
        ptl_div_cell #(.QW(DW), .UW(UW)) u_cell_x (
            .clk     (clk),
            .rem_in  (divx_rem[k]),
            .num_in  (divx_num[k]),
            .quo_in  (divx_quo[k]),
            .uu_in   (divx_uu[k]),
            .rem_out (divx_rem[k+1]),
            .num_out (divx_num[k+1]),
            .quo_out (divx_quo[k+1]),
            .uu_out  (divx_uu[k+1])
        );
        ptl_div_cell #(.QW(DW), .UW(UW)) u_cell_y (
            .clk     (clk),
            .rem_in  (divy_rem[k]),
            .num_in  (divy_num[k]),
            .quo_in  (divy_quo[k]),
            .uu_in   (divy_uu[k]),
            .rem_out (divy_rem[k+1]),
            .num_out (divy_num[k+1]),
            .quo_out (divy_quo[k+1]),
            .uu_out  (divy_uu[k+1])
        );
        if (k == 0)
        begin : g_first
            always_ff @(posedge clk)
            begin
                dside_reg[k] <= s5_side_reg;
            end
        end
        else
        begin : g_rest
            always_ff @(posedge clk)
            begin
                dside_reg[k] <= dside_reg[k-1];
            end
        end
    end

    // stage 6: projection and perpendicular vector
    logic signed [DW-1:0] d6_dx, d6_dy;
    logic                 d6_negx, d6_negy, d6_deg;
    logic signed [DW:0]   proj_x, proj_y;
    logic signed [DW:0]   s6_px_next, s6_py_next;
    logic signed [DW:0]   s6_px_reg, s6_py_reg;
    logic                 s6_deg_reg;

    assign {d6_dx, d6_dy, d6_negx, d6_negy, d6_deg} = dside_reg[DW-1];
    assign proj_x = d6_deg ? '0
                  : (d6_negx ? -$signed({1'b0, divx_quo[DW]}) : $signed({1'b0, divx_quo[DW]}));
    assign proj_y = d6_deg ? '0
                  : (d6_negy ? -$signed({1'b0, divy_quo[DW]}) : $signed({1'b0, divy_quo[DW]}));
    assign s6_px_next = proj_x - $signed({d6_dx[DW-1], d6_dx});
    assign s6_py_next = proj_y - $signed({d6_dy[DW-1], d6_dy});

    // stage 7: squares and saturation
    logic [W-1:0]           sat_x, sat_y;
    logic                   fit_x, fit_y;
    logic signed [2*DW+1:0] s7_sqx_reg, s7_sqy_reg;
    logic [W-1:0]           s7_satx_reg, s7_saty_reg;
    logic                   s7_ovf_reg, s7_deg_reg;

    assign fit_x = (s6_px_reg[DW:W-1] == '0) || (s6_px_reg[DW:W-1] == '1);
    assign fit_y = (s6_py_reg[DW:W-1] == '0) || (s6_py_reg[DW:W-1] == '1);
    assign sat_x = fit_x ? s6_px_reg[W-1:0]
                 : (s6_px_reg[DW] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}});
    assign sat_y = fit_y ? s6_py_reg[W-1:0]
                 : (s6_py_reg[DW] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}});

    // stage 8: sum of squares
    logic [2*W+2:0] s8_sum_next;
    logic [2*W+2:0] s8_sum_reg;
    logic [SSW-1:0] s8_side_reg;

    assign s8_sum_next = {1'b0, s7_sqx_reg[2*W+1:0]} + {1'b0, s7_sqy_reg[2*W+1:0]};

    always_ff @(posedge clk)
    begin
        s6_px_reg   <= s6_px_next;
        s6_py_reg   <= s6_py_next;
        s6_deg_reg  <= d6_deg;

        s7_sqx_reg  <= s6_px_reg * s6_px_reg;
        s7_sqy_reg  <= s6_py_reg * s6_py_reg;
        s7_satx_reg <= sat_x;
        s7_saty_reg <= sat_y;
        s7_ovf_reg  <= !fit_x || !fit_y;
        s7_deg_reg  <= s6_deg_reg;

        s8_sum_reg  <= s8_sum_next;
        s8_side_reg <= {s7_satx_reg, s7_saty_reg, s7_ovf_reg, s7_deg_reg};
    end

    // root row, one result bit per cell
    logic [RW+1:0]   sq_rem  [RW+1];
    logic [2*RW-1:0] sq_src  [RW+1];
    logic [RW-1:0]   sq_root [RW+1];
    logic [SSW-1:0]  sside_reg [RW];

    assign sq_rem[0]  = '0;
    assign sq_src[0]  = {1'b0, s8_sum_reg};
    assign sq_root[0] = '0;

    for (genvar k = 0; k < RW; k++)
    begin : g_sqrt
        ptl_sqrt_cell #(.RW(RW)) u_cell (
            .clk      (clk),
            .rem_in   (sq_rem[k]),
            .src_in   (sq_src[k]),
            .root_in  (sq_root[k]),
            .rem_out  (sq_rem[k+1]),
            .src_out  (sq_src[k+1]),
            .root_out (sq_root[k+1])
        );
        if (k == 0)
        begin : g_first
            always_ff @(posedge clk)
            begin
                sside_reg[k] <= s8_side_reg;
            end
        end
        else
        begin : g_rest
            always_ff @(posedge clk)
            begin
                sside_reg[k] <= sside_reg[k-1];
            end
        end
    end

    // output stage
    logic [W-1:0] o_satx, o_saty;
    logic         o_ovf, o_deg, o_big;
    logic [W-1:0] px_reg, py_reg, dist_reg;
    logic         ovf_reg, deg_reg;

    assign {o_satx, o_saty, o_ovf, o_deg} = sside_reg[RW-1];
    assign o_big = (sq_root[RW][RW-1:W] != '0);

    always_ff @(posedge clk)
    begin
        px_reg   <= o_satx;
        py_reg   <= o_saty;
        dist_reg <= o_big ? '1 : sq_root[RW][W-1:0];
        ovf_reg  <= o_ovf || o_big;
        deg_reg  <= o_deg;
    end

    assign done       = vld_reg[LAT-1];
    assign perp_x     = $signed(px_reg);
    assign perp_y     = $signed(py_reg);
    assign distance   = dist_reg;
    assign overflow   = ovf_reg;
    assign degenerate = deg_reg;

    localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LAT done)
        else $error("item result not delivered after pipeline latency");

    a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (done && overflow) |-> ((distance == '1) || (px_reg == SMAX) || (px_reg == SMIN)
                                || (py_reg == SMAX) || (py_reg == SMIN)))
        else $error("overflow flagged without a saturated field");

    a_zero_dist: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (px_reg == '0) && (py_reg == '0)) |-> (distance == '0))
        else $error("zero vector with nonzero distance");

endmodule

[bench/tb_point_to_line_distance_core.sv]
module tb_point_to_line_distance_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W = ptl_pkg::COORD_WIDTH_DEF;
    localparam int LATENCY = 2 * W + 12;

    typedef struct packed {
        logic signed [W-1:0] sx, sy, ex, ey, px, py;
    } query_t;

    typedef struct packed {
        logic signed [W-1:0] perp_x, perp_y;
        logic [W-1:0]        distance;
        logic                overflow, degenerate;
    } offset_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [W-1:0] line_start_x = '0, line_start_y = '0;
    logic signed [W-1:0] line_end_x = '0, line_end_y = '0;
    logic signed [W-1:0] point_x = '0, point_y = '0;
    logic done;
    logic signed [W-1:0] perp_x, perp_y;
    logic [W-1:0] distance;
    logic overflow, degenerate;

    query_t  pending_queries[$];
    offset_t expected_offsets[$];
    int      idle_pct = 36;
    logic    hold = 1'b0;
    logic    all_queued = 1'b0;
    int      errors = 0;

    point_to_line_distance_core DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .line_start_x(line_start_x), .line_start_y(line_start_y),
        .line_end_x(line_end_x), .line_end_y(line_end_y),
        .point_x(point_x), .point_y(point_y),
        .done(done), .perp_x(perp_x), .perp_y(perp_y), .distance(distance),
        .overflow(overflow), .degenerate(degenerate)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [63:0] isqrt(input logic [127:0] s);
        logic [63:0]  r;
        logic [63:0]  t;
        logic [127:0] tw;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            tw = {64'd0, t};
            if (tw * tw <= s)
                r = t;
        end
        return r;
    endfunction

    function automatic logic signed [W-1:0] clamp(input longint v, inout logic ovf);
        longint hi;
        longint lo;
        hi = (longint'(1) << (W - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
        begin
            ovf = 1'b1;
            return hi[W-1:0];
        end
        if (v < lo)
        begin
            ovf = 1'b1;
            return lo[W-1:0];
        end
        return v[W-1:0];
    endfunction

    function automatic offset_t predict_offset(input query_t q);
        offset_t o;
        longint dx, dy, ux, uy, projx, projy, perpx, perpy;
        logic signed [127:0] dot, uu, sum;
        logic [63:0] root;
        logic ovf;
        dx = longint'(q.px) - longint'(q.sx);
        dy = longint'(q.py) - longint'(q.sy);
        ux = longint'(q.ex) - longint'(q.sx);
        uy = longint'(q.ey) - longint'(q.sy);
        projx = 0;
        projy = 0;
        ovf = 1'b0;
        o.degenerate = (ux == 0 && uy == 0);
        if (!o.degenerate)
        begin
            dot = 128'(dx) * 128'(ux) + 128'(dy) * 128'(uy);
            uu = 128'(ux) * 128'(ux) + 128'(uy) * 128'(uy);
            // signed division truncates toward zero
            projx = longint'((dot * 128'(ux)) / uu);
            projy = longint'((dot * 128'(uy)) / uu);
        end
        perpx = projx - dx;
        perpy = projy - dy;
        sum = 128'(perpx) * 128'(perpx) + 128'(perpy) * 128'(perpy);
        root = isqrt(sum);
        if (root > {{(64-W){1'b0}}, {W{1'b1}}})
        begin
            root = {{(64-W){1'b0}}, {W{1'b1}}};
            ovf = 1'b1;
        end
        o.distance = root[W-1:0];
        o.perp_x = clamp(perpx, ovf);
        o.perp_y = clamp(perpy, ovf);
        o.overflow = ovf;
        return o;
    endfunction

    function automatic logic [W-1:0] rand_coord();
        case ($urandom_range(0, 5)) inside
            0: return $urandom_range(0, 1) ? {1'b0, {(W-1){1'b1}}} : {1'b1, {(W-1){1'b0}}};
            [1:2]: return W'($signed($urandom_range(0, 8000)) - 4000);
            default: return W'($urandom);
        endcase
    endfunction

    function automatic query_t rand_query();
        query_t q;
        q.sx = rand_coord();
        q.sy = rand_coord();
        q.px = rand_coord();
        q.py = rand_coord();
        case ($urandom_range(0, 9)) inside
            0:
            begin
                q.ex = q.sx;
                q.ey = q.sy;
            end
            [1:2]:
            begin
                q.ex = q.sx + W'($signed($urandom_range(0, 6)) - 3);
                q.ey = q.sy + W'($signed($urandom_range(0, 6)) - 3);
            end
            default:
            begin
                q.ex = rand_coord();
                q.ey = rand_coord();
            end
        endcase
        return q;
    endfunction

    task automatic report_mismatch(input string what, input logic [W-1:0] got,
                                   input logic [W-1:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // driver: a new item goes out at the falling edge once the last one was taken
    always @(negedge clk)
    begin
        query_t q;
        logic   go;
        go = start && busy;
        if (!(start && busy) && rst_n && !hold && pending_queries.size() > 0
            && $urandom_range(1, 100) > idle_pct)
        begin
            q = pending_queries.pop_front();
            {line_start_x, line_start_y, line_end_x, line_end_y, point_x, point_y} <= q;
            go = 1'b1;
        end
        start <= go;
    end

    // monitor
    always @(posedge clk)
    begin
        offset_t e;
        if (rst_n && done)
        begin
            if (expected_offsets.size() == 0)
            begin
                report_mismatch("unexpected done", W'(done), '0);
            end
            else
            begin
                e = expected_offsets.pop_front();
                if (perp_x !== e.perp_x) report_mismatch("perp_x", perp_x, e.perp_x);
                if (perp_y !== e.perp_y) report_mismatch("perp_y", perp_y, e.perp_y);
                if (distance !== e.distance)
                    report_mismatch("distance", distance, e.distance);
                if (overflow !== e.overflow)
                    report_mismatch("overflow", W'(overflow), W'(e.overflow));
                if (degenerate !== e.degenerate)
                    report_mismatch("degenerate", W'(degenerate), W'(e.degenerate));
            end
        end
        if (rst_n && start && !busy)
            expected_offsets.push_back(predict_offset({line_start_x, line_start_y,
                line_end_x, line_end_y, point_x, point_y}));
    end

    initial
    begin
        logic [W-1:0] mx, mn;
        mx = {1'b0, {(W-1){1'b1}}};
        mn = {1'b1, {(W-1){1'b0}}};
        repeat (7) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        pending_queries.push_back('{0, 0, 0, 0, 0, 0});
        pending_queries.push_back('{mx, mx, mx, mx, mx, mx});
        pending_queries.push_back('{mn, mn, mn, mn, mn, mn});
        // zero-length line, offset too large to fit
        pending_queries.push_back('{mn, mn, mn, mn, mx, mx});
        pending_queries.push_back('{mx, mn, mx, mn, mn, mx});
        // longest line, far point
        pending_queries.push_back('{mn, mn, mx, mx, mx, mn});
        pending_queries.push_back('{mn, mx, mx, mn, mn, mn});
        pending_queries.push_back('{mx, 0, mn, 0, 0, mx});
        pending_queries.push_back('{0, mn, 0, mx, mn, 0});
        // point on the line
        pending_queries.push_back('{0, 0, 32'h10000, 32'h10000, 32'h30000, 32'h30000});
        pending_queries.push_back('{0, 0, 32'h10000, 0, 32'h5000, 32'h7000});
        pending_queries.push_back('{0, 0, 0, 1, -32'sd7, 32'h12345});
        pending_queries.push_back('{1, 2, 4, 6, -32'sd3, 9});
        pending_queries.push_back('{5, 5, 6, 5, 5, 5});
        pending_queries.push_back('{32'hffffffff, 0, 0, 32'hffffffff, mx, mn});

        for (int i = 0; i < 650; i++) pending_queries.push_back(rand_query());
        wait (pending_queries.size() == 0);
        idle_pct = 76;
        for (int i = 0; i < 650; i++) pending_queries.push_back(rand_query());
        wait (pending_queries.size() == 0);

        // drain fully before the last phase
        hold = 1'b1;
        @(negedge clk);
        wait (expected_offsets.size() == 0 && !start);
        @(negedge clk) hold = 1'b0;

        idle_pct = 0;
        for (int i = 0; i < 635; i++) pending_queries.push_back(rand_query());
        all_queued = 1'b1;
    end

    initial
    begin
        wait (rst_n);
        wait (all_queued);
        wait (pending_queries.size() == 0);
        @(negedge clk);
        wait (!start && expected_offsets.size() == 0);
        repeat (LATENCY + 20) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

endmodule

[filelist.f]
rtl/ptl_pkg.sv
rtl/ptl_div_cell.sv
rtl/ptl_sqrt_cell.sv
rtl/point_to_line_distance_core.sv
bench/tb_point_to_line_distance_core.sv
